FILE: rtl/falru_pkg.sv
// Shared types and constants for the fully associative LRU tag store.
// No dependencies; used by falru_lookup, falru_state and the top level.
`default_nettype none
package falru_pkg;

	localparam int AddrW   = 32;  // byte address width
	localparam int TagW    = 32;  // stored tag width
	localparam int OffsetW = 5;   // width of the offset register
	localparam int WayW    = 4;   // width of the reported way index

	localparam logic [OffsetW-1:0] OffsetReset = 5'd5;

	// Outcome of one lookup: hit flag and the way hit, filled or replaced.
	typedef struct packed {
		logic            hit;
		logic [WayW-1:0] way;
	} lookup_t;

endpackage
`default_nettype wire

FILE: rtl/falru_lookup.sv
// Tag compare and victim selection for the LRU tag store.
// Pure combinational; depends on falru_pkg.
`default_nettype none
module falru_lookup #(
	parameter int WAYS  = 4,
	parameter int RankW = 2
) (
	input  wire logic [falru_pkg::TagW-1:0]            tag,
	input  wire logic [WAYS-1:0]                       valid_vec,
	input  wire logic [WAYS-1:0][falru_pkg::TagW-1:0]  tags,
	input  wire logic [WAYS-1:0][RankW-1:0]            ranks,
	output falru_pkg::lookup_t                         result
);

	localparam logic [RankW-1:0] OldestRank = RankW'(WAYS - 1);

	logic [WAYS-1:0]           match;
	logic                      any_match;
	logic [falru_pkg::WayW-1:0] match_way;
	logic                      any_free;
	logic [falru_pkg::WayW-1:0] free_way;
	logic [falru_pkg::WayW-1:0] lru_way;

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			match[i] = valid_vec[i] && (tags[i] == tag);
		end
	end

	// Priority encoders: scan downward so the lowest index wins.
	always_comb begin
		any_match = 1'b0;
		match_way = '0;
		any_free  = 1'b0;
		free_way  = '0;
		lru_way   = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				any_match = 1'b1;
				match_way = falru_pkg::WayW'(i);
			end
			if (!valid_vec[i]) begin
				any_free = 1'b1;
				free_way = falru_pkg::WayW'(i);
			end
			if (ranks[i] == OldestRank) begin
				lru_way = falru_pkg::WayW'(i);
			end
		end
	end

	always_comb begin
		result.hit = any_match;
		if (any_match) begin
			result.way = match_way;
		end else if (any_free) begin
			result.way = free_way;
		end else begin
			result.way = lru_way;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/falru_state.sv
// Valid bits, tags and recency ranks of the LRU tag store, with their update.
// Depends on falru_pkg.
`default_nettype none
module falru_state #(
	parameter int WAYS  = 4,
	parameter int RankW = 2
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  update,
	input  wire logic [falru_pkg::TagW-1:0]            tag,
	input  wire falru_pkg::lookup_t                    result,
	output logic [WAYS-1:0]                            valid_vec,
	output logic [WAYS-1:0][falru_pkg::TagW-1:0]       tags,
	output logic [WAYS-1:0][RankW-1:0]                 ranks
);

	localparam int IdxW = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [WAYS-1:0]            valid_q;
	logic [WAYS-1:0][falru_pkg::TagW-1:0] tags_q;
	logic [WAYS-1:0][RankW-1:0] ranks_q;
	logic [WAYS-1:0][RankW-1:0] ranks_next;
	logic [IdxW-1:0]            idx;
	logic [RankW-1:0]           old_rank;

	assign idx      = result.way[IdxW-1:0];
	assign old_rank = ranks_q[idx];

	// Touch: the chosen way goes to rank 0, more recent ways age by one.
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			if (IdxW'(i) == idx) begin
				ranks_next[i] = '0;
			end else if (ranks_q[i] < old_rank) begin
				ranks_next[i] = ranks_q[i] + 1'b1;
			end else begin
				ranks_next[i] = ranks_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < WAYS; i++) begin
				ranks_q[i] <= RankW'(i);
			end
		end else if (update) begin
			ranks_q <= ranks_next;
			if (!result.hit) begin
				valid_q[idx] <= 1'b1;
			end
		end
	end

	// Tags carry no reset; a tag is read only behind its valid bit.
	always_ff @(posedge clk) begin
		if (update && !result.hit) begin
			tags_q[idx] <= tag;
		end
	end

	assign valid_vec = valid_q;
	assign tags      = tags_q;
	assign ranks     = ranks_q;

endmodule
`default_nettype wire

FILE: rtl/fully_associative_lru_tag_store_unit.sv
// Top level of the fully associative LRU tag store.
// Depends on falru_pkg, falru_lookup and falru_state.
//
// Fully associative tag store with LRU replacement. Each item is one byte
// address; its tag is the address shifted right by the offset register
// (reset 5), written by the user through cfg_we/cfg_wdata only while the
// block is idle; the block does not check this. A valid matching way
// reports hit=1 with that way and becomes most recent. On a miss the
// lowest-index invalid way is filled, or else the least recently used way
// is replaced; that way takes the tag, becomes most recent and is reported
// with hit=0. It sustains one item per clock while not stalled. An input
// register feeds one pass of tag compare, priority select and state update
// that writes the result register. The compare across all WAYS tags plus
// the priority encoders set the clock path. A stalled result holds the
// input register; the next item already in it sees the state left by the
// one ahead, since the state updates on the same edge that loads the result register.
`default_nettype none
module fully_associative_lru_tag_store_unit #(
	parameter int WAYS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [falru_pkg::OffsetW-1:0] cfg_wdata,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [falru_pkg::AddrW-1:0]   address,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               hit,
	output logic [falru_pkg::WayW-1:0]         way
);

	localparam int RankW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int IdxW  = RankW;

	logic [falru_pkg::OffsetW-1:0] offset_q;

	// stage 1: input register
	logic                          valid_s1;
	logic [falru_pkg::AddrW-1:0]   address_s1;
	// stage 2: result register
	logic                          valid_s2;
	falru_pkg::lookup_t            result_s2;

	logic                          advance;
	logic [falru_pkg::TagW-1:0]    tag;
	falru_pkg::lookup_t            result;
	logic [WAYS-1:0]               valid_vec;
	logic [WAYS-1:0][falru_pkg::TagW-1:0] tags;
	logic [WAYS-1:0][RankW-1:0]    ranks;

	// offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= falru_pkg::OffsetReset;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	// The item in stage 1 moves on when the result register is free or drains.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			address_s1 <= address;
		end
	end

	assign tag = address_s1 >> offset_q;

	falru_lookup #(
		.WAYS  (WAYS),
		.RankW (RankW)
	) u_lookup (
		.tag       (tag),
		.valid_vec (valid_vec),
		.tags      (tags),
		.ranks     (ranks),
		.result    (result)
	);

	falru_state #(
		.WAYS  (WAYS),
		.RankW (RankW)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (advance),
		.tag       (tag),
		.result    (result),
		.valid_vec (valid_vec),
		.tags      (tags),
		.ranks     (ranks)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign hit       = result_s2.hit;
	assign way       = result_s2.way;

`ifndef SYNTHESIS
	// An empty result register never holds back the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with an empty result register");

	// A processed item always lands in the result register.
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("processed item lost");

	// The reported way is valid and most recent right after its update.
	a_way_touched: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (valid_vec[result_s2.way[IdxW-1:0]]
			&& (ranks[result_s2.way[IdxW-1:0]] == '0)))
		else $error("reported way not valid or not most recent");

	// A hit can only name a valid way.
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.hit) |-> valid_vec[result_s2.way[IdxW-1:0]])
		else $error("hit reported on an invalid way");
`endif

endmodule
`default_nettype wire

FILE: sim/falru_checker.sv
// Checker for the fully associative LRU tag store: watches the config port and both
// item channels, predicts each lookup and compares it with the block's results.
// Depends on falru_pkg.
module falru_checker #(
	parameter int WAYS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [falru_pkg::OffsetW-1:0] cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [falru_pkg::AddrW-1:0]   address,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          hit,
	input  logic [falru_pkg::WayW-1:0]    way,
	output int                            failures,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RankW = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef struct {
		logic [falru_pkg::AddrW-1:0] addr;
		falru_pkg::lookup_t          result;
	} lookup_entry_t;

	// shadow copy of the tag store
	logic [falru_pkg::OffsetW-1:0] offset_q;
	logic                          valid_q [WAYS];
	logic [falru_pkg::TagW-1:0]    tag_q   [WAYS];
	logic [RankW-1:0]              rank_q  [WAYS];

	lookup_entry_t expected_lookups[$];
	int            mismatch_count = 0;

	assign failures = mismatch_count;

	task automatic record_mismatch(input string what);
		if (mismatch_count < 10) begin
			$display("%0t ns mismatch: %s", $time, what);
		end
		mismatch_count++;
	endtask

	// rank 0 is most recent; ways that were more recent than w age by one
	function automatic void promote_way(input int w);
		logic [RankW-1:0] old_rank;
		old_rank = rank_q[w];
		for (int i = 0; i < WAYS; i++) begin
			if (rank_q[i] < old_rank) begin
				rank_q[i] = rank_q[i] + 1'b1;
			end
		end
		rank_q[w] = '0;
	endfunction

	function automatic falru_pkg::lookup_t lookup_and_update(
		input logic [falru_pkg::AddrW-1:0] addr);
		logic [falru_pkg::TagW-1:0] tag;
		int                         w;
		bit                         found;
		bit                         picked;
		falru_pkg::lookup_t         r;
		tag    = falru_pkg::TagW'(addr >> offset_q);
		w      = 0;
		found  = 1'b0;
		picked = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			if (!found && valid_q[i] && tag_q[i] == tag) begin
				w     = i;
				found = 1'b1;
			end
		end
		if (!found) begin
			// cold ways fill in index order before anything is evicted
			for (int i = 0; i < WAYS; i++) begin
				if (!picked && !valid_q[i]) begin
					w      = i;
					picked = 1'b1;
				end
			end
			if (!picked) begin
				for (int i = 0; i < WAYS; i++) begin
					if (rank_q[i] == RankW'(WAYS - 1)) begin
						w = i;
					end
				end
			end
			valid_q[w] = 1'b1;
			tag_q[w]   = tag;
		end
		promote_way(w);
		r.hit = found;
		r.way = falru_pkg::WayW'(w);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		lookup_entry_t oldest;
		lookup_entry_t fresh;
		if (!arst_n) begin
			offset_q = falru_pkg::OffsetReset;
			for (int i = 0; i < WAYS; i++) begin
				valid_q[i] = 1'b0;
				tag_q[i]   = '0;
				rank_q[i]  = RankW'(i);
			end
			expected_lookups.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_lookups.size() == 0) begin
					record_mismatch($sformatf("result hit=%0b way=%0d with no item pending",
						hit, way));
				end else begin
					oldest = expected_lookups.pop_front();
					if (oldest.result.hit !== hit || oldest.result.way !== way) begin
						record_mismatch($sformatf(
							"addr %08h: expected hit=%0b way=%0d, got hit=%0b way=%0d",
							oldest.addr, oldest.result.hit, oldest.result.way, hit, way));
					end
				end
			end
			if (cfg_we) begin
				offset_q = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				fresh.addr   = address;
				fresh.result = lookup_and_update(address);
				expected_lookups.push_back(fresh);
			end
			outstanding <= expected_lookups.size();
		end
	end

endmodule

FILE: sim/fully_associative_lru_tag_store_unit_tb.sv
// Testbench top for fully_associative_lru_tag_store_unit: drives address items and
// the offset register, randomizes result back-pressure and reports the verdict.
// Depends on falru_pkg, falru_checker and the block's RTL.
module fully_associative_lru_tag_store_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WAYS         = 4;
	localparam int HoldCycles   = 80;   // long receiver stall that fills the pipe
	localparam int PhaseItems   = 80;   // random items per offset setting
	localparam int Phases       = 6;
	localparam int DrainCycles  = 10;   // settle time after the last result

	// Cold fill under the reset offset (5): four fills with a hit inside the first
	// line, then LRU replacement once every way is valid.
	localparam logic [falru_pkg::AddrW-1:0] ColdFill [9] = '{
		32'h0000_0000, 32'h0000_001f, 32'h0000_0020, 32'hffff_ffff,
		32'h0000_0040, 32'h0000_0080, 32'h0000_003f, 32'hffff_ffe0,
		32'h0000_0000
	};
	// Shift of zero: every address bit is part of the tag.
	localparam logic [falru_pkg::AddrW-1:0] WholeAddr [6] = '{
		32'h0000_0000, 32'h0000_0001, 32'h0000_0000,
		32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000
	};
	// Largest shift: only the top address bit survives, so tags are 0 or 1.
	localparam logic [falru_pkg::AddrW-1:0] TopBit [5] = '{
		32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000,
		32'hc000_0000
	};
	localparam logic [falru_pkg::OffsetW-1:0] PhaseOffsets [Phases] = '{
		5'd12, 5'd31, 5'd0, 5'd5, 5'd3, 5'd20
	};

	// every block input starts at a known value
	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [falru_pkg::OffsetW-1:0]  cfg_wdata = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic [falru_pkg::AddrW-1:0]    address   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           hit;
	logic [falru_pkg::WayW-1:0]     way;

	int                             failures;
	int                             outstanding;

	// handshake between the stimulus and the receiver for the long stall
	bit                             hold_request = 1'b0;
	bit                             hold_done    = 1'b0;

	// stimulus-side view of the offset, used to aim addresses at live lines
	logic [falru_pkg::OffsetW-1:0]  offset_now = falru_pkg::OffsetReset;
	logic [falru_pkg::AddrW-1:0]    hot_lines[$];

	fully_associative_lru_tag_store_unit #(
		.WAYS(WAYS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.address  (address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit      (hit),
		.way      (way)
	);

	falru_checker #(
		.WAYS(WAYS)
	) lookup_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.address    (address),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.way        (way),
		.failures   (failures),
		.outstanding(outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Idle length shared by both sides: mostly none or short, now and then long.
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 20);
	endfunction

	// Refill the working set; its size straddles the way count so that the
	// random part sees both steady hits and LRU evictions.
	function automatic void reseed_hot_lines();
		hot_lines.delete();
		repeat ($urandom_range(2, WAYS + 2)) begin
			hot_lines.push_back($urandom());
		end
	endfunction

	// Mostly re-touch a hot line with random bits below the offset, which
	// keeps the tag; sometimes bring in a new line or a stray address.
	function automatic logic [falru_pkg::AddrW-1:0] next_address();
		logic [falru_pkg::AddrW-1:0] line_mask;
		logic [falru_pkg::AddrW-1:0] fresh;
		int                          roll;
		int                          slot;
		roll      = $urandom_range(0, 99);
		line_mask = (falru_pkg::AddrW'(1) << offset_now) - 1'b1;
		if (roll < 12) begin
			return $urandom();
		end
		slot = $urandom_range(0, hot_lines.size() - 1);
		if (roll < 30) begin
			fresh           = $urandom();
			hot_lines[slot] = fresh;
			return fresh;
		end
		return (hot_lines[slot] & ~line_mask) | ($urandom() & line_mask);
	endfunction

	// Offer one item after an optional gap and hold it until accepted. Valid is
	// only lowered when a gap follows, so it never drops and rises in one step.
	task automatic offer_address(input logic [falru_pkg::AddrW-1:0] addr, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		address  <= addr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Offset writes go in only once every result has come back.
	task automatic set_offset(input logic [falru_pkg::OffsetW-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= value;
		offset_now = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side: ready runs of random length with idle gaps between them,
	// and one long stall on request while the sender keeps offering items.
	initial begin
		int run;
		int gap;
		wait (arst_n);
		forever begin
			if (hold_request && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= 1'b1;
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
				                                  : $urandom_range(1, 6);
				repeat (run) @(posedge clk);
				gap = idle_length();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		bit quiet;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: cold fill and replacement, then both shift extremes
		foreach (ColdFill[i]) offer_address(ColdFill[i], idle_length());
		set_offset(5'd0);
		foreach (WholeAddr[i]) offer_address(WholeAddr[i], idle_length());
		set_offset(5'd31);
		foreach (TopBit[i]) offer_address(TopBit[i], idle_length());

		// random part, one offset setting per phase
		for (int phase = 0; phase < Phases; phase++) begin
			set_offset((phase == 3) ? falru_pkg::OffsetW'($urandom_range(1, 30))
			                        : PhaseOffsets[phase]);
			reseed_hot_lines();
			// two phases run the sender with no gaps at all
			quiet = (phase == 2 || phase == 4);
			if (phase == 1) begin
				// back-to-back items for as long as the receiver holds off
				hold_request = 1'b1;
				while (!hold_done) offer_address(next_address(), 0);
			end
			repeat (PhaseItems) offer_address(next_address(), quiet ? 0 : idle_length());
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
